/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* design/rm_pkg.sv */
// ----------------------------------------------------------------------------
// Running median package
// Sizes, payload types and the control bundle of the sorting cell chain.
// ----------------------------------------------------------------------------
package rm_pkg;

  localparam int CAPACITY    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int MED_BITS    = SAMPLE_BITS + 1;
  localparam int CNT_BITS    = $clog2(CAPACITY + 1);
  localparam int IDX_BITS    = $clog2(CAPACITY);
  localparam int GROUP_SIZE  = 16;
  localparam int GROUPS      = CAPACITY / GROUP_SIZE;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MED_BITS-1:0]    med_t;
  typedef logic [CNT_BITS-1:0]           cnt_t;
  typedef logic [IDX_BITS-1:0]           idx_t;

  typedef struct packed {
    logic    insert;
    sample_t sample;
    cnt_t    occupied;
    idx_t    hi_idx;
    idx_t    lo_idx;
  } cell_ctrl_t;

endpackage

/* design/rm_if.sv */
// ----------------------------------------------------------------------------
// Running median stream interfaces
// Valid/ready channels for samples in and medians out.
// ----------------------------------------------------------------------------
interface rm_in_if;
  logic             valid;
  logic             ready;
  rm_pkg::sample_t  sample;
  logic             restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rm_out_if;
  logic          valid;
  logic          ready;
  rm_pkg::med_t  median_doubled;
  rm_pkg::cnt_t  sample_total;
  logic          overflow;

  modport source (output valid, output median_doubled, output sample_total,
                  output overflow, input ready);
  modport sink   (input valid, input median_doubled, input sample_total,
                  input overflow, output ready);
endinterface

/* design/rm_cell.sv */
// ----------------------------------------------------------------------------
// Running median sorting cell
// Holds one sorted sample; on insert takes its left neighbour, the new
// sample or keeps its own, and offers its value for median selection.
// ----------------------------------------------------------------------------
module rm_cell (
  input  logic               clk_i,
  input  rm_pkg::idx_t       idx_i,
  input  rm_pkg::cell_ctrl_t ctrl_i,
  input  logic               left_gt_i,
  input  rm_pkg::sample_t    left_val_i,
  output rm_pkg::sample_t    val_o,
  output logic               gt_o,
  output rm_pkg::sample_t    hi_o,
  output rm_pkg::sample_t    lo_o
);

  rm_pkg::sample_t val_q, val_d;
  logic            occ;

  assign occ   = rm_pkg::cnt_t'(idx_i) < ctrl_i.occupied;
  assign gt_o  = !occ || (val_q > ctrl_i.sample);
  assign val_o = val_q;
  assign hi_o  = (idx_i == ctrl_i.hi_idx) ? val_q : '0;
  assign lo_o  = (idx_i == ctrl_i.lo_idx) ? val_q : '0;

  always_comb begin
    val_d = val_q;
    priority if (!ctrl_i.insert) begin
      val_d = val_q;
    end else if (left_gt_i) begin
      val_d = left_val_i;
    end else if (gt_o) begin
      val_d = ctrl_i.sample;
    end else begin
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* design/rm_chain.sv */
// ----------------------------------------------------------------------------
// Running median cell chain
// Row of sorting cells with a registered first level of median selection.
// ----------------------------------------------------------------------------
module rm_chain (
  input  logic               clk_i,
  input  rm_pkg::cell_ctrl_t ctrl_i,
  input  logic               grp_en_i,
  output rm_pkg::sample_t    hi_grp_o [rm_pkg::GROUPS],
  output rm_pkg::sample_t    lo_grp_o [rm_pkg::GROUPS]
);

  rm_pkg::sample_t val   [rm_pkg::CAPACITY];
  logic            gt    [rm_pkg::CAPACITY];
  rm_pkg::sample_t hi    [rm_pkg::CAPACITY];
  rm_pkg::sample_t lo    [rm_pkg::CAPACITY];
  rm_pkg::sample_t hi_grp_q [rm_pkg::GROUPS];
  rm_pkg::sample_t lo_grp_q [rm_pkg::GROUPS];
  rm_pkg::sample_t hi_grp_d [rm_pkg::GROUPS];
  rm_pkg::sample_t lo_grp_d [rm_pkg::GROUPS];

  for (genvar i = 0; i < rm_pkg::CAPACITY; i++) begin : g_cell
    logic            left_gt;
    rm_pkg::sample_t left_val;
    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_next
      assign left_gt  = gt[i-1];
      assign left_val = val[i-1];
    end
    rm_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (rm_pkg::idx_t'(i)),
      .ctrl_i     (ctrl_i),
      .left_gt_i  (left_gt),
      .left_val_i (left_val),
      .val_o      (val[i]),
      .gt_o       (gt[i]),
      .hi_o       (hi[i]),
      .lo_o       (lo[i])
    );
  end

  always_comb begin
    for (int g = 0; g < rm_pkg::GROUPS; g++) begin
      hi_grp_d[g] = '0;
      lo_grp_d[g] = '0;
      for (int k = 0; k < rm_pkg::GROUP_SIZE; k++) begin
        hi_grp_d[g] = hi_grp_d[g] | hi[g*rm_pkg::GROUP_SIZE + k];
        lo_grp_d[g] = lo_grp_d[g] | lo[g*rm_pkg::GROUP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_en_i) begin
      hi_grp_q <= hi_grp_d;
      lo_grp_q <= lo_grp_d;
    end
  end

  assign hi_grp_o = hi_grp_q;
  assign lo_grp_o = lo_grp_q;

endmodule

/* design/running_median.sv */
// ----------------------------------------------------------------------------
// Running median
// Median of all samples since the last restart, kept in a sorting cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries sample and restart; a transaction is one new sample.
//   out_o carries median_doubled (twice the median, exact), sample_total
//   and overflow; every input transaction yields one output transaction.
//   Restart empties the store before its sample is inserted. With the
//   store full and no restart, the sample is dropped and overflow is set.
// Timing:
//   The sample is inserted into the cell chain on the accepting edge; its
//   result then passes the group registers and the output register. One
//   sample is in work at a time; a new one is taken only once the last
//   result is in the output register. Steps: insert, registered group
//   selection over sixteen cells, final selection and the add.
// Reset and stall:
//   Reset empties the store and clears all valid flags. A stalled output
//   holds its result; a result waiting in the selection stage holds off
//   the next sample until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module running_median (
  input  logic       clk_i,
  input  logic       rst_ni,
  rm_in_if.sink      in_i,
  rm_out_if.source   out_o
);

  logic               accept, full, out_load;
  rm_pkg::cnt_t       count_q, count_d, eff_count;
  logic               p1_v_q, p2_v_q, out_v_q;
  rm_pkg::cnt_t       tot_q;
  logic               ovf_q;
  rm_pkg::cell_ctrl_t ctrl;
  rm_pkg::idx_t       half;
  rm_pkg::sample_t    hi_grp [rm_pkg::GROUPS];
  rm_pkg::sample_t    lo_grp [rm_pkg::GROUPS];
  rm_pkg::sample_t    hi_val, lo_val;
  rm_pkg::med_t       med_d, med_q;
  rm_pkg::cnt_t       out_tot_q;
  logic               out_ovf_q;

  assign in_i.ready = !p1_v_q && !p2_v_q;
  assign accept     = in_i.valid && in_i.ready;
  assign eff_count  = in_i.restart ? '0 : count_q;
  assign full       = eff_count == rm_pkg::cnt_t'(rm_pkg::CAPACITY);
  assign count_d    = !accept ? count_q
                    : full    ? eff_count
                    :           eff_count + rm_pkg::cnt_t'(1);

  assign half          = count_q[rm_pkg::CNT_BITS-1:1];
  assign ctrl.insert   = accept && !full;
  assign ctrl.sample   = in_i.sample;
  assign ctrl.occupied = eff_count;
  assign ctrl.hi_idx   = half;
  assign ctrl.lo_idx   = count_q[0] ? half : half - rm_pkg::idx_t'(1);

  rm_chain u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .grp_en_i (p1_v_q),
    .hi_grp_o (hi_grp),
    .lo_grp_o (lo_grp)
  );

  always_comb begin
    hi_val = '0;
    lo_val = '0;
    for (int g = 0; g < rm_pkg::GROUPS; g++) begin
      hi_val = hi_val | hi_grp[g];
      lo_val = lo_val | lo_grp[g];
    end
    med_d = rm_pkg::med_t'(hi_val) + rm_pkg::med_t'(lo_val);
  end

  assign out_load = p2_v_q && (!out_v_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      count_q <= count_d;
      p1_v_q  <= accept;
      if (p1_v_q) begin
        p2_v_q <= 1'b1;
      end else if (out_load) begin
        p2_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tot_q <= count_d;
      ovf_q <= full;
    end
    if (out_load) begin
      med_q     <= med_d;
      out_tot_q <= tot_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.median_doubled = med_q;
  assign out_o.sample_total   = out_tot_q;
  assign out_o.overflow       = out_ovf_q;

  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > rm_pkg::cnt_t'(rm_pkg::CAPACITY), "count above capacity")
  `ASSERT_NEVER(a_stage_excl, clk_i, rst_ni, p1_v_q && p2_v_q, "two samples in the selection stages")
  `ASSERT_PROP(a_accept_p1, clk_i, rst_ni, accept |=> p1_v_q && count_q != '0, "accepted sample not staged")
  `ASSERT_PROP(a_ovf_full, clk_i, rst_ni, (out_v_q && out_ovf_q) |-> out_tot_q == rm_pkg::cnt_t'(rm_pkg::CAPACITY), "overflow without full store")

endmodule
